### rtl/etr_pkg.sv
// ----------------------------------------------------------------------------
// etr_pkg
// Shared types, codes and helpers for the telemetry frame receiver.
// ----------------------------------------------------------------------------
package etr_pkg;

  // input item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result record kinds
  typedef enum logic [1:0] {
    REC_STATUS   = 2'd0,
    REC_FRAME_OK = 2'd1,
    REC_FRAME_BAD = 2'd2,
    REC_EXTREMES = 2'd3
  } rec_kind_t;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT = 4'd1;

  localparam logic [7:0]  GAP_LIMIT_RESET    = 8'd20;
  localparam logic [15:0] LINK_TIMEOUT_RESET = 16'd500;

  localparam logic [7:0]  CRC_POLY       = 8'hD5;
  localparam logic [8:0]  SINCE_BYTE_MAX = 9'd511;
  localparam logic [15:0] SINCE_GOOD_MAX = 16'hFFFF;
  localparam logic [10:0] RATE_MAX       = 11'd2047;

  typedef struct packed {
    rec_kind_t   record_kind;
    logic        last_of_run;
    logic [7:0]  temperature;
    logic [15:0] voltage;
    logic [15:0] current;
    logic [15:0] erpm;
    logic [15:0] consumption_or_min_voltage;
    logic        link_up;
    logic [10:0] frame_rate;
    logic [31:0] good_frames;
    logic [31:0] crc_errors;
  } result_t;

  // one byte of crc-8, msb first, no reflection
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/etr_in_if.sv
// ----------------------------------------------------------------------------
// etr_in_if
// Input channel: received bytes and millisecond ticks.
// ----------------------------------------------------------------------------
interface etr_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, operation, data_byte, input ready);
  modport sink   (input valid, operation, data_byte, output ready);
endinterface

### rtl/etr_out_if.sv
// ----------------------------------------------------------------------------
// etr_out_if
// Result channel: status, frame and extremes records.
// ----------------------------------------------------------------------------
interface etr_out_if;
  logic              valid;
  logic              ready;
  etr_pkg::rec_kind_t record_kind;
  logic              last_of_run;
  logic [7:0]        temperature;
  logic [15:0]       voltage;
  logic [15:0]       current;
  logic [15:0]       erpm;
  logic [15:0]       consumption_or_min_voltage;
  logic              link_up;
  logic [10:0]       frame_rate;
  logic [31:0]       good_frames;
  logic [31:0]       crc_errors;

  modport source (output valid, record_kind, last_of_run, temperature, voltage, current,
                  erpm, consumption_or_min_voltage, link_up, frame_rate, good_frames,
                  crc_errors, input ready);
  modport sink   (input valid, record_kind, last_of_run, temperature, voltage, current,
                  erpm, consumption_or_min_voltage, link_up, frame_rate, good_frames,
                  crc_errors, output ready);
endinterface

### rtl/etr_cfg_if.sv
// ----------------------------------------------------------------------------
// etr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface etr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [etr_pkg::CFG_IDX_W-1:0]  index;
  logic [etr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/esc_telemetry_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// esc_telemetry_frame_receiver_unit
// Gathers telemetry frames byte by byte, checks crc-8, unpacks the fields and
// keeps link, rate, counters and extremes, driven by millisecond ticks.
// ----------------------------------------------------------------------------
// Output: a beat's records are registered into the result queue and leave from its head.
// Throughput: one input beat per cycle while the 4-entry result queue has room
// for two records; a good frame end queues two records, a tick or a bad frame
// end one, so sustained rate is set by the result port, one record per cycle.
// Reset: synchronous, active low; clears position, crc, timers, counters,
// extremes and the queue, and loads gap limit 20 and link timeout 500.
// ----------------------------------------------------------------------------
module esc_telemetry_frame_receiver_unit #(
  parameter int FRAME_BYTES       = 10,
  parameter int RATE_WINDOW_TICKS = 1000
) (
  input  logic      clk,
  input  logic      rst_n,
  etr_in_if.sink    in_ch,
  etr_out_if.source out_ch,
  etr_cfg_if.sink   cfg_ch
);

  localparam int DEPTH = FRAME_BYTES - 1;
  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [9:0] WINDOW_END = 10'(RATE_WINDOW_TICKS);

  // configuration
  logic [7:0]  gap_limit_r;
  logic [15:0] link_timeout_r;

  // receiver state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       store_r [DEPTH];
  logic [8:0]       since_byte_r, since_byte_nxt;
  logic [15:0]      since_good_r, since_good_nxt;
  logic [9:0]       window_r, window_nxt;
  logic [10:0]      frames_r, frames_nxt;
  logic [10:0]      rate_r, rate_nxt;
  logic [31:0]      good_r, good_nxt;
  logic [31:0]      bad_r, bad_nxt;

  // last good frame
  logic [7:0]  lv_temp_r, lv_temp_nxt;
  logic [15:0] lv_volt_r, lv_volt_nxt;
  logic [15:0] lv_cur_r, lv_cur_nxt;
  logic [15:0] lv_cons_r, lv_cons_nxt;
  logic [15:0] lv_rpm_r, lv_rpm_nxt;

  // extremes
  logic [7:0]  ex_temp_r, ex_temp_nxt;
  logic [15:0] ex_vpeak_r, ex_vpeak_nxt;
  logic [15:0] ex_cur_r, ex_cur_nxt;
  logic [15:0] ex_rpm_r, ex_rpm_nxt;
  logic [15:0] ex_vmin_r, ex_vmin_nxt;

  // result queue
  etr_pkg::result_t q_r [4];
  logic [1:0] head_r, head_nxt;
  logic [1:0] tail_r, tail_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  logic             in_acc;
  logic             out_pop;
  logic             store_wr;
  logic [POS_W-1:0] pos_eff;
  logic [7:0]       crc_eff;
  logic [1:0]       n_push;
  logic             link;
  logic [9:0]       window_inc;
  logic [7:0]       pb [9];
  logic [15:0]      f_volt, f_cur, f_cons, f_rpm;
  etr_pkg::result_t rec0, rec1;

  assign in_ch.ready  = (cnt_r <= 3'd2);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (cnt_r != 3'd0);
  assign out_pop      = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // payload bytes past the stored part of a short frame read as zero
  for (genvar k = 0; k < 9; k++) begin : g_pb
    if (k < DEPTH) begin : g_have
      assign pb[k] = store_r[k];
    end else begin : g_zero
      assign pb[k] = 8'd0;
    end
  end

  assign f_volt = {pb[1], pb[2]};
  assign f_cur  = {pb[3], pb[4]};
  assign f_cons = {pb[5], pb[6]};
  assign f_rpm  = {pb[7], pb[8]};

  // gap resync ahead of the byte
  assign pos_eff = (pos_r != '0 && since_byte_r > {1'b0, gap_limit_r}) ? '0 : pos_r;
  assign crc_eff = (pos_r != '0 && since_byte_r > {1'b0, gap_limit_r}) ? 8'd0 : crc_r;
  assign window_inc = window_r + 10'd1;

  always_comb begin
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    since_byte_nxt = since_byte_r;
    since_good_nxt = since_good_r;
    window_nxt     = window_r;
    frames_nxt     = frames_r;
    rate_nxt       = rate_r;
    good_nxt       = good_r;
    bad_nxt        = bad_r;
    lv_temp_nxt    = lv_temp_r;
    lv_volt_nxt    = lv_volt_r;
    lv_cur_nxt     = lv_cur_r;
    lv_cons_nxt    = lv_cons_r;
    lv_rpm_nxt     = lv_rpm_r;
    ex_temp_nxt    = ex_temp_r;
    ex_vpeak_nxt   = ex_vpeak_r;
    ex_cur_nxt     = ex_cur_r;
    ex_rpm_nxt     = ex_rpm_r;
    ex_vmin_nxt    = ex_vmin_r;
    store_wr       = 1'b0;
    n_push         = 2'd0;
    rec0.record_kind = etr_pkg::REC_STATUS;
    rec0.last_of_run = 1'b1;
    if (in_acc) begin
      if (in_ch.operation == etr_pkg::OP_TICK) begin
        if (since_byte_r < etr_pkg::SINCE_BYTE_MAX) since_byte_nxt = since_byte_r + 9'd1;
        if (since_good_r < etr_pkg::SINCE_GOOD_MAX) since_good_nxt = since_good_r + 16'd1;
        window_nxt = window_inc;
        if (window_inc >= WINDOW_END) begin
          rate_nxt   = frames_r;
          frames_nxt = 11'd0;
          window_nxt = 10'd0;
        end
        n_push = 2'd1;
      end else begin
        since_byte_nxt = 9'd0;
        if (pos_eff < LAST_POS) begin
          store_wr = 1'b1;
          crc_nxt  = etr_pkg::crc8_step(crc_eff, in_ch.data_byte);
          pos_nxt  = pos_eff + POS_W'(1);
        end else begin
          pos_nxt = '0;
          crc_nxt = 8'd0;
          if (in_ch.data_byte != crc_eff) begin
            bad_nxt          = bad_r + 32'd1;
            n_push           = 2'd1;
            rec0.record_kind = etr_pkg::REC_FRAME_BAD;
          end else begin
            lv_temp_nxt    = pb[0];
            lv_volt_nxt    = f_volt;
            lv_cur_nxt     = f_cur;
            lv_cons_nxt    = f_cons;
            lv_rpm_nxt     = f_rpm;
            good_nxt       = good_r + 32'd1;
            since_good_nxt = 16'd0;
            if (frames_r < etr_pkg::RATE_MAX) frames_nxt = frames_r + 11'd1;
            if (pb[0] > ex_temp_r)   ex_temp_nxt  = pb[0];
            if (f_cur > ex_cur_r)    ex_cur_nxt   = f_cur;
            if (f_rpm > ex_rpm_r)    ex_rpm_nxt   = f_rpm;
            if (f_volt > ex_vpeak_r) ex_vpeak_nxt = f_volt;
            if (f_volt != 16'd0 && (ex_vmin_r == 16'd0 || f_volt < ex_vmin_r)) begin
              ex_vmin_nxt = f_volt;
            end
            n_push           = 2'd2;
            rec0.record_kind = etr_pkg::REC_FRAME_OK;
            rec0.last_of_run = 1'b0;
          end
        end
      end
    end

    // status after this beat has been applied
    link = (link_timeout_r != 16'd0) && (good_nxt != 32'd0) &&
           (since_good_nxt < link_timeout_r);

    rec0.temperature                = lv_temp_nxt;
    rec0.voltage                    = lv_volt_nxt;
    rec0.current                    = lv_cur_nxt;
    rec0.erpm                       = lv_rpm_nxt;
    rec0.consumption_or_min_voltage = lv_cons_nxt;
    rec0.link_up                    = link;
    rec0.frame_rate                 = rate_nxt;
    rec0.good_frames                = good_nxt;
    rec0.crc_errors                 = bad_nxt;

    rec1.record_kind                = etr_pkg::REC_EXTREMES;
    rec1.last_of_run                = 1'b1;
    rec1.temperature                = ex_temp_nxt;
    rec1.voltage                    = ex_vpeak_nxt;
    rec1.current                    = ex_cur_nxt;
    rec1.erpm                       = ex_rpm_nxt;
    rec1.consumption_or_min_voltage = ex_vmin_nxt;
    rec1.link_up                    = link;
    rec1.frame_rate                 = rate_nxt;
    rec1.good_frames                = good_nxt;
    rec1.crc_errors                 = bad_nxt;
  end

  always_comb begin
    tail_nxt = tail_r + n_push;
    head_nxt = head_r + {1'b0, out_pop};
    cnt_nxt  = cnt_r + {1'b0, n_push} - {2'b00, out_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r    <= etr_pkg::GAP_LIMIT_RESET;
      link_timeout_r <= etr_pkg::LINK_TIMEOUT_RESET;
      pos_r          <= '0;
      crc_r          <= 8'd0;
      since_byte_r   <= 9'd0;
      since_good_r   <= 16'd0;
      window_r       <= 10'd0;
      frames_r       <= 11'd0;
      rate_r         <= 11'd0;
      good_r         <= 32'd0;
      bad_r          <= 32'd0;
      lv_temp_r      <= 8'd0;
      lv_volt_r      <= 16'd0;
      lv_cur_r       <= 16'd0;
      lv_cons_r      <= 16'd0;
      lv_rpm_r       <= 16'd0;
      ex_temp_r      <= 8'd0;
      ex_vpeak_r     <= 16'd0;
      ex_cur_r       <= 16'd0;
      ex_rpm_r       <= 16'd0;
      ex_vmin_r      <= 16'd0;
      head_r         <= 2'd0;
      tail_r         <= 2'd0;
      cnt_r          <= 3'd0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          etr_pkg::CFG_GAP_LIMIT:    gap_limit_r    <= cfg_ch.data[7:0];
          etr_pkg::CFG_LINK_TIMEOUT: link_timeout_r <= cfg_ch.data;
          default: ;
        endcase
      end
      pos_r        <= pos_nxt;
      crc_r        <= crc_nxt;
      since_byte_r <= since_byte_nxt;
      since_good_r <= since_good_nxt;
      window_r     <= window_nxt;
      frames_r     <= frames_nxt;
      rate_r       <= rate_nxt;
      good_r       <= good_nxt;
      bad_r        <= bad_nxt;
      lv_temp_r    <= lv_temp_nxt;
      lv_volt_r    <= lv_volt_nxt;
      lv_cur_r     <= lv_cur_nxt;
      lv_cons_r    <= lv_cons_nxt;
      lv_rpm_r     <= lv_rpm_nxt;
      ex_temp_r    <= ex_temp_nxt;
      ex_vpeak_r   <= ex_vpeak_nxt;
      ex_cur_r     <= ex_cur_nxt;
      ex_rpm_r     <= ex_rpm_nxt;
      ex_vmin_r    <= ex_vmin_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // frame byte store and result queue payload, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (store_wr && pos_eff == POS_W'(i)) store_r[i] <= in_ch.data_byte;
    end
    if (n_push != 2'd0) q_r[tail_r] <= rec0;
    if (n_push == 2'd2) q_r[tail_r + 2'd1] <= rec1;
  end

  assign out_ch.record_kind                = q_r[head_r].record_kind;
  assign out_ch.last_of_run                = q_r[head_r].last_of_run;
  assign out_ch.temperature                = q_r[head_r].temperature;
  assign out_ch.voltage                    = q_r[head_r].voltage;
  assign out_ch.current                    = q_r[head_r].current;
  assign out_ch.erpm                       = q_r[head_r].erpm;
  assign out_ch.consumption_or_min_voltage = q_r[head_r].consumption_or_min_voltage;
  assign out_ch.link_up                    = q_r[head_r].link_up;
  assign out_ch.frame_rate                 = q_r[head_r].frame_rate;
  assign out_ch.good_frames                = q_r[head_r].good_frames;
  assign out_ch.crc_errors                 = q_r[head_r].crc_errors;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds serial bytes and millisecond ticks to the telemetry frame receiver,
// first from a short table of stimulus and then as random frames, corrupt
// frames, gaps and noise under several register settings and handshake
// pressures. Every record is checked field by field against a local model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FRAME_LEN   = 10;
  localparam int RATE_WINDOW = 1000;
  localparam int SETTLE      = 4;
  localparam int HOLD_CYCLES = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_DIRECTED  = 25;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CRC, ROW_CFG} row_act_t;

  typedef struct packed {
    row_act_t                      act;
    logic                          op;
    logic [15:0]                   val;
    logic [etr_pkg::CFG_IDX_W-1:0] idx;
    logic                          chk;
    etr_pkg::rec_kind_t            kind;
    logic [31:0]                   good;
    logic [31:0]                   bad;
    logic                          link;
  } stim_row_t;

  typedef struct packed {
    logic [7:0]  temp;
    logic [15:0] volt;
    logic [15:0] cur;
    logic [15:0] cons;
    logic [15:0] rpm;
  } telem_vals_t;

  typedef struct packed {
    logic [7:0]  temp;
    logic [15:0] volt_pk;
    logic [15:0] cur;
    logic [15:0] rpm;
    logic [15:0] volt_min;
  } telem_peaks_t;

  // kind, good, bad and link typed in only where obvious
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{ROW_ITEM, etr_pkg::OP_TICK, 16'h0000, etr_pkg::CFG_GAP_LIMIT, 1'b1,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_CFG,  etr_pkg::OP_BYTE, 16'h0001, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h00FF, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_TICK, 16'h0000, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_TICK, 16'h00FF, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h0000, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h0000, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h0000, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h0000, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h0000, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h0000, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h0000, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h0000, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h0000, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h0001, etr_pkg::CFG_GAP_LIMIT, 1'b1,
      etr_pkg::REC_FRAME_BAD, 32'd0, 32'd1, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h00FF, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h00FF, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h00FF, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h00FF, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h00FF, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h00FF, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h00FF, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h00FF, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_ITEM, etr_pkg::OP_BYTE, 16'h00FF, etr_pkg::CFG_GAP_LIMIT, 1'b0,
      etr_pkg::REC_STATUS,    32'd0, 32'd0, 1'b0},
    '{ROW_CRC,  etr_pkg::OP_BYTE, 16'h0000, etr_pkg::CFG_GAP_LIMIT, 1'b1,
      etr_pkg::REC_EXTREMES,  32'd1, 32'd1, 1'b1}
  };

  logic clk = 1'b0;
  logic rst_n;

  etr_in_if  in_bus();
  etr_out_if out_bus();
  etr_cfg_if cfg_bus();

  esc_telemetry_frame_receiver_unit #(
    .FRAME_BYTES      (FRAME_LEN),
    .RATE_WINDOW_TICKS(RATE_WINDOW)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  always #5 clk = ~clk;

  // receiver model state
  logic [7:0]   gap_limit;
  logic [15:0]  link_timeout;
  logic [3:0]   rx_pos;
  logic [7:0]   rx_crc;
  logic [7:0]   rx_bytes [FRAME_LEN-1];
  logic [8:0]   ms_since_byte;
  logic [15:0]  ms_since_good;
  logic [9:0]   window_ms;
  logic [10:0]  frames_win;
  logic [10:0]  rate_val;
  logic [31:0]  good_frames;
  logic [31:0]  crc_errs;
  telem_vals_t  last_vals;
  telem_peaks_t peaks;

  etr_pkg::result_t telemetry_records_due [$];
  int      records_added;
  int      items_sent;
  int      fail_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct;
  int      stall_pct;
  int      hold_token;
  int      hold_seen = 0;
  int      hold_left = 0;

  function automatic logic [7:0] crc_next(logic [7:0] acc, logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ etr_pkg::CRC_POLY) : {c[6:0], 1'b0};
    return c;
  endfunction

  function automatic void queue_record(etr_pkg::rec_kind_t kind, logic last,
                                       logic [7:0] t, logic [15:0] v, logic [15:0] c,
                                       logic [15:0] r, logic [15:0] x);
    etr_pkg::result_t rec;
    rec.record_kind                = kind;
    rec.last_of_run                = last;
    rec.temperature                = t;
    rec.voltage                    = v;
    rec.current                    = c;
    rec.erpm                       = r;
    rec.consumption_or_min_voltage = x;
    rec.link_up     = (link_timeout != 0) && (good_frames != 0) &&
                      (ms_since_good < link_timeout);
    rec.frame_rate  = rate_val;
    rec.good_frames = good_frames;
    rec.crc_errors  = crc_errs;
    telemetry_records_due.push_back(rec);
    records_added++;
  endfunction

  function automatic void apply_telemetry_item(logic op, logic [7:0] b);
    telem_vals_t f;
    records_added = 0;
    if (op == etr_pkg::OP_TICK) begin
      if (ms_since_byte < etr_pkg::SINCE_BYTE_MAX) ms_since_byte++;
      if (ms_since_good < etr_pkg::SINCE_GOOD_MAX) ms_since_good++;
      window_ms = window_ms + 10'd1;
      if (window_ms >= RATE_WINDOW) begin
        rate_val   = frames_win;
        frames_win = '0;
        window_ms  = '0;
      end
      queue_record(etr_pkg::REC_STATUS, 1'b1, last_vals.temp, last_vals.volt,
                   last_vals.cur, last_vals.rpm, last_vals.cons);
      return;
    end
    // a long enough gap throws away a partial frame
    if (rx_pos != 0 && ms_since_byte > gap_limit) begin
      rx_pos = '0;
      rx_crc = '0;
    end
    ms_since_byte = '0;
    if (rx_pos < FRAME_LEN - 1) begin
      rx_bytes[rx_pos] = b;
      rx_crc = crc_next(rx_crc, b);
      rx_pos = rx_pos + 4'd1;
      return;
    end
    rx_pos = '0;
    if (b != rx_crc) begin
      rx_crc = '0;
      crc_errs++;
      queue_record(etr_pkg::REC_FRAME_BAD, 1'b1, last_vals.temp, last_vals.volt,
                   last_vals.cur, last_vals.rpm, last_vals.cons);
      return;
    end
    rx_crc = '0;
    f.temp = rx_bytes[0];
    f.volt = {rx_bytes[1], rx_bytes[2]};
    f.cur  = {rx_bytes[3], rx_bytes[4]};
    f.cons = {rx_bytes[5], rx_bytes[6]};
    f.rpm  = {rx_bytes[7], rx_bytes[8]};
    last_vals = f;
    good_frames++;
    ms_since_good = '0;
    if (frames_win < etr_pkg::RATE_MAX) frames_win++;
    if (f.temp > peaks.temp) peaks.temp = f.temp;
    if (f.cur > peaks.cur) peaks.cur = f.cur;
    if (f.rpm > peaks.rpm) peaks.rpm = f.rpm;
    if (f.volt > peaks.volt_pk) peaks.volt_pk = f.volt;
    // zero voltage never counts as a minimum
    if (f.volt != 0 && (peaks.volt_min == 0 || f.volt < peaks.volt_min)) begin
      peaks.volt_min = f.volt;
    end
    queue_record(etr_pkg::REC_FRAME_OK, 1'b0, f.temp, f.volt, f.cur, f.rpm, f.cons);
    queue_record(etr_pkg::REC_EXTREMES, 1'b1, peaks.temp, peaks.volt_pk, peaks.cur,
                 peaks.rpm, peaks.volt_min);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic logic [7:0] payload_byte();
    unique case ($urandom_range(0, 9))
      0, 1: return 8'h00;
      2: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // called at a falling edge; valid stays high into the next beat
  task automatic send_beat(input logic op, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.data_byte <= b;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    apply_telemetry_item(op, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (telemetry_records_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [etr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    if (idx == etr_pkg::CFG_GAP_LIMIT) begin
      gap_limit = val[7:0];
    end else if (idx == etr_pkg::CFG_LINK_TIMEOUT) begin
      link_timeout = val;
    end
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_phase(input logic [7:0] gap, input logic [15:0] link,
                           input int idle, input int stall);
    write_reg(etr_pkg::CFG_GAP_LIMIT, {8'($urandom_range(0, 255)), gap});
    write_reg(etr_pkg::CFG_LINK_TIMEOUT, link);
    send_idle_pct = idle;
    stall_pct     = stall;
  endtask

  task automatic send_frame(input bit intact);
    logic [7:0] b;
    bit         zero_volt;
    int         k;
    zero_volt = ($urandom_range(0, 9) == 0);
    // realign before a fresh frame
    while (rx_pos != 0) send_beat(etr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
    for (k = 0; k < FRAME_LEN - 1; k++) begin
      b = payload_byte();
      if (zero_volt && (k == 1 || k == 2)) b = 8'h00;
      send_beat(etr_pkg::OP_BYTE, b);
      if ($urandom_range(0, 9) == 0) begin
        send_beat(etr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
      end
    end
    send_beat(etr_pkg::OP_BYTE, intact ? rx_crc : rx_crc ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic run_random(input int count);
    int target;
    int pick;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(1'b1);
      end else if (pick < 68) begin
        send_frame(1'b0);
      end else if (pick < 78) begin
        // partial frame, then, for a gap limit up to 40, a gap long enough to drop it
        repeat ($urandom_range(1, FRAME_LEN - 2)) send_beat(etr_pkg::OP_BYTE, payload_byte());
        if (gap_limit <= 40) begin
          repeat (int'(gap_limit) + 1 + $urandom_range(0, 1)) begin
            send_beat(etr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
          end
        end
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) send_beat(etr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // result side: random stalls plus a long hold-off each time hold_token is bumped
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_records
    etr_pkg::result_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (telemetry_records_due.size() == 0) begin
        $error("unexpected record beat, kind %0d", out_bus.record_kind);
        fail_count++;
      end else begin
        want = telemetry_records_due.pop_front();
        check_field("record_kind", want.record_kind, out_bus.record_kind);
        check_field("last_of_run", want.last_of_run, out_bus.last_of_run);
        check_field("temperature", want.temperature, out_bus.temperature);
        check_field("voltage", want.voltage, out_bus.voltage);
        check_field("current", want.current, out_bus.current);
        check_field("erpm", want.erpm, out_bus.erpm);
        check_field("consumption_or_min_voltage", want.consumption_or_min_voltage,
                    out_bus.consumption_or_min_voltage);
        check_field("link_up", want.link_up, out_bus.link_up);
        check_field("frame_rate", want.frame_rate, out_bus.frame_rate);
        check_field("good_frames", want.good_frames, out_bus.good_frames);
        check_field("crc_errors", want.crc_errors, out_bus.crc_errors);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("esc_telemetry_frame_receiver_unit verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t        r;
    etr_pkg::result_t rec;
    int               i;
    int               j;
    int               n;

    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.operation  = etr_pkg::OP_BYTE;
    in_bus.data_byte  = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = etr_pkg::CFG_GAP_LIMIT;
    cfg_bus.data      = '0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    hold_token        = 0;
    items_sent        = 0;
    records_added     = 0;
    gap_limit         = etr_pkg::GAP_LIMIT_RESET;
    link_timeout      = etr_pkg::LINK_TIMEOUT_RESET;
    rx_pos            = '0;
    rx_crc            = '0;
    ms_since_byte     = '0;
    ms_since_good     = '0;
    window_ms         = '0;
    frames_win        = '0;
    rate_val          = '0;
    good_frames       = '0;
    crc_errs          = '0;
    last_vals         = '0;
    peaks             = '0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      r = DIRECTED_ROWS[i];
      unique case (r.act)
        ROW_CFG: begin
          write_reg(r.idx, r.val);
        end
        ROW_CRC: begin
          send_beat(etr_pkg::OP_BYTE, rx_crc);
        end
        default: begin
          send_beat(r.op, r.val[7:0]);
        end
      endcase
      if (r.chk && r.act != ROW_CFG) begin
        // the beat's records are still at the back of the queue here
        n = telemetry_records_due.size();
        for (j = n - records_added; j < n; j++) begin
          rec             = telemetry_records_due[j];
          rec.good_frames = r.good;
          rec.crc_errors  = r.bad;
          rec.link_up     = r.link;
          if (j == n - 1) rec.record_kind = r.kind;
          telemetry_records_due[j] = rec;
        end
      end
    end

    set_phase(8'd20, 16'd500, 0, 0);
    run_random(170);

    set_phase(8'd1, 16'd1, 67, 0);
    run_random(170);

    // long tick run: saturates the byte gap timer and closes a rate window
    set_phase(8'd255, 16'hFFFF, 0, 67);
    send_beat(etr_pkg::OP_BYTE, payload_byte());
    repeat (1000) send_beat(etr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    run_random(170);

    // zero gap limit and zero link timeout
    set_phase(8'd0, 16'd0, 24, 24);
    run_random(170);

    set_phase(8'd3, 16'd40, 0, 0);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    hold_token++;
    @(negedge clk);
    // ticks keep coming while results are held back
    repeat (30) send_beat(etr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    wait_drained();
    run_random(170);

    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("esc_telemetry_frame_receiver_unit verification clean");
    end else begin
      $display("esc_telemetry_frame_receiver_unit verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/etr_pkg.sv
rtl/etr_in_if.sv
rtl/etr_out_if.sv
rtl/etr_cfg_if.sv
rtl/esc_telemetry_frame_receiver_unit.sv
verif/testbench.sv
